>>> src/first_fit_partition_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Standalone header; the files that assert include it by name.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define FFPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ffpa_pkg.sv
// Shared types and constants for the first-fit partition allocator.
// No dependencies.
`default_nettype none

package ffpa_pkg;

  // Parameter defaults
  localparam int DEF_MAX_PARTS  = 16;
  localparam int DEF_SIZE_BITS  = 16;
  localparam int DEF_OWNER_BITS = 16;

  // Fixed field widths
  localparam int ADDR_W    = 20;
  localparam int IDX_OUT_W = 4;
  localparam int AMT_W     = 16;
  localparam int OWN_IN_W  = 16;
  localparam int CNT_CFG_W = 5;
  localparam int PADDR_W   = 3;

  localparam logic [CNT_CFG_W-1:0] CNT_RESET = 5'd16;

  // Register select (paddr[2]) of partition_count
  localparam logic REG_PART_COUNT = 1'b0;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_e;

  // One result item
  typedef struct packed {
    logic                 status;
    logic [IDX_OUT_W-1:0] index;
    logic [ADDR_W-1:0]    start;
  } res_t;

  // Table write commands
  typedef struct packed {
    logic load;
    logic set_used;
    logic clr_used;
  } tbl_cmd_t;

endpackage

`default_nettype wire

>>> src/ffpa_table.sv
// Partition table: size, start and owner memories plus per-entry used bits.
// Depends on ffpa_pkg.
`default_nettype none

module ffpa_table #(
  parameter int MAX_PARTS  = 16,
  parameter int SIZE_BITS  = 16,
  parameter int OWNER_BITS = 16,
  parameter int IDX_W      = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ffpa_pkg::tbl_cmd_t     cmd_i,
  input  wire logic [IDX_W-1:0]       wr_idx_i,
  input  wire logic [SIZE_BITS-1:0]   wr_size_i,
  input  wire logic [ffpa_pkg::ADDR_W-1:0] wr_start_i,
  input  wire logic [OWNER_BITS-1:0]  wr_owner_i,
  input  wire logic                   rd_en_i,
  input  wire logic [IDX_W-1:0]       rd_idx_i,
  output logic      [SIZE_BITS-1:0]   rd_size_o,
  output logic      [ffpa_pkg::ADDR_W-1:0] rd_start_o,
  output logic      [OWNER_BITS-1:0]  rd_owner_o,
  output logic                        rd_used_o
);
  import ffpa_pkg::*;

  logic [SIZE_BITS-1:0]  size_mem  [MAX_PARTS];
  logic [ADDR_W-1:0]     start_mem [MAX_PARTS];
  logic [OWNER_BITS-1:0] owner_mem [MAX_PARTS];
  logic [MAX_PARTS-1:0]  used_q;

  // Memory writes: load sets size and start, allocate sets owner
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_mem[wr_idx_i]  <= wr_size_i;
      start_mem[wr_idx_i] <= wr_start_i;
    end
    if (cmd_i.set_used) begin
      owner_mem[wr_idx_i] <= wr_owner_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_size_o  <= size_mem[rd_idx_i];
      rd_start_o <= start_mem[rd_idx_i];
      rd_owner_o <= owner_mem[rd_idx_i];
      rd_used_o  <= used_q[rd_idx_i];
    end
  end

  // Used bits, all free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.set_used) begin
      used_q[wr_idx_i] <= 1'b1;
    end else if (cmd_i.load || cmd_i.clr_used) begin
      used_q[wr_idx_i] <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/ffpa_seq.sv
// Sequencer with the shared entry compare unit: one table entry per cycle.
// Depends on ffpa_pkg and first_fit_partition_allocator_macros.svh.
`default_nettype none

`include "first_fit_partition_allocator_macros.svh"

module ffpa_seq #(
  parameter int MAX_PARTS  = 16,
  parameter int SIZE_BITS  = 16,
  parameter int OWNER_BITS = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire ffpa_pkg::op_e                in_op_i,
  input  wire logic [ffpa_pkg::IDX_OUT_W-1:0] in_index_i,
  input  wire logic [ffpa_pkg::AMT_W-1:0]   in_amount_i,
  input  wire logic [ffpa_pkg::OWN_IN_W-1:0] in_owner_i,
  input  wire logic [ffpa_pkg::CNT_CFG_W-1:0] part_count_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output ffpa_pkg::res_t                    res_o,
  output ffpa_pkg::tbl_cmd_t                tbl_cmd_o,
  output logic      [IDX_W-1:0]             tbl_wr_idx_o,
  output logic      [SIZE_BITS-1:0]         tbl_wr_size_o,
  output logic      [ffpa_pkg::ADDR_W-1:0]  tbl_wr_start_o,
  output logic      [OWNER_BITS-1:0]        tbl_wr_owner_o,
  output logic                              tbl_rd_en_o,
  output logic      [IDX_W-1:0]             tbl_rd_idx_o,
  input  wire logic [SIZE_BITS-1:0]         tbl_rd_size_i,
  input  wire logic [ffpa_pkg::ADDR_W-1:0]  tbl_rd_start_i,
  input  wire logic [OWNER_BITS-1:0]        tbl_rd_owner_i,
  input  wire logic                         tbl_rd_used_i
);
  import ffpa_pkg::*;

  seq_state_e            state_q, state_d;
  op_e                   op_q, op_d;
  logic [SIZE_BITS-1:0]  req_q, req_d;
  logic [OWNER_BITS-1:0] own_q, own_d;
  logic [CNT_W-1:0]      limit_q, limit_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [IDX_W-1:0]      chk_q, chk_d;
  logic                  pend_q, pend_d;
  logic [ADDR_W-1:0]     next_addr_q, next_addr_d;
  res_t                  res_q, res_d;

  logic [CNT_W-1:0]      limit_in;
  logic                  load_ok;
  logic [ADDR_W-1:0]     load_base;
  logic [SIZE_BITS-1:0]  size_in;
  logic                  size_fit;
  logic                  owner_eq;
  logic                  hit;

  // Scan limit: partition_count clipped to the table depth
  assign limit_in = (32'(part_count_i) > 32'(MAX_PARTS)) ? CNT_W'(MAX_PARTS)
                                                         : CNT_W'(part_count_i);
  assign load_ok   = 32'(in_index_i) < 32'(MAX_PARTS);
  assign load_base = (in_index_i == '0) ? '0 : next_addr_q;
  assign size_in   = SIZE_BITS'(in_amount_i);

  // Shared compare unit on the entry read last cycle
  assign size_fit = tbl_rd_size_i >= req_q;
  assign owner_eq = tbl_rd_owner_i == own_q;
  assign hit = pend_q && ((op_q == OP_ALLOC) ? (!tbl_rd_used_i && size_fit)
                                             : (tbl_rd_used_i && owner_eq));

  assign tbl_wr_size_o  = size_in;
  assign tbl_wr_start_o = load_base;
  assign tbl_wr_owner_o = own_q;
  assign tbl_rd_idx_o   = ptr_q[IDX_W-1:0];
  assign res_o          = res_q;

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    req_d       = req_q;
    own_d       = own_q;
    limit_d     = limit_q;
    ptr_d       = ptr_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    next_addr_d = next_addr_q;
    res_d       = res_q;
    tbl_cmd_o   = '0;
    tbl_wr_idx_o = chk_q;
    tbl_rd_en_o = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        tbl_wr_idx_o = IDX_W'(in_index_i);
        if (in_valid_i) begin
          op_d    = in_op_i;
          req_d   = size_in;
          own_d   = OWNER_BITS'(in_owner_i);
          limit_d = limit_in;
          ptr_d   = '0;
          pend_d  = 1'b0;
          res_d   = '{status: STATUS_FAIL, index: '0, start: '0};
          state_d = ST_FINISH;
          case (in_op_i)
            OP_LOAD: begin
              if (load_ok) begin
                tbl_cmd_o.load = 1'b1;
                next_addr_d = load_base + ADDR_W'(size_in);
                res_d = '{status: STATUS_OK, index: '0, start: load_base};
              end
            end
            OP_ALLOC, OP_RELEASE: begin
              if (limit_in != '0) begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next entry read while checking the previous one
        tbl_rd_en_o = ptr_q < limit_q;
        pend_d      = tbl_rd_en_o;
        chk_d       = ptr_q[IDX_W-1:0];
        if (tbl_rd_en_o) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (hit) begin
          tbl_cmd_o.set_used = (op_q == OP_ALLOC);
          tbl_cmd_o.clr_used = (op_q == OP_RELEASE);
          res_d = '{status: STATUS_OK, index: IDX_OUT_W'(chk_q), start: tbl_rd_start_i};
          pend_d  = 1'b0;
          state_d = ST_FINISH;
        end else if (!pend_q && !tbl_rd_en_o) begin
          res_d   = '{status: STATUS_FAIL, index: '0, start: '0};
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      ptr_q       <= '0;
      limit_q     <= '0;
      next_addr_q <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      ptr_q       <= ptr_d;
      limit_q     <= limit_d;
      next_addr_q <= next_addr_d;
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    req_q <= req_d;
    own_q <= own_d;
    chk_q <= chk_d;
    res_q <= res_d;
  end

  `FFPA_ASSERT_IMP(a_set_in_scan, clk_i, rst_ni, tbl_cmd_o.set_used, (state_q == ST_SCAN) && pend_q, "allocate write outside a scan check")
  `FFPA_ASSERT_IMP(a_ptr_bound, clk_i, rst_ni, state_q == ST_SCAN, ptr_q <= limit_q, "scan pointer past limit")
  `FFPA_ASSERT_IMP(a_hit_bound, clk_i, rst_ni, hit, 32'(chk_q) < 32'(limit_q), "hit on entry beyond limit")
  `FFPA_ASSERT_NEXT(a_load_done, clk_i, rst_ni, in_valid_i && in_ready_o && (in_op_i == OP_LOAD), state_q == ST_FINISH, "load did not finish in one cycle")

endmodule

`default_nettype wire

>>> src/first_fit_partition_allocator.sv
// First-fit fixed-partition allocator. Each accepted item yields one result.
// A load (and an allocate or release with partition_count zero) goes from
// accept straight to the finish state, which offers its result. An allocate
// or release scans entries one per cycle through a single registered table
// read port and one shared compare unit: each entry is read, then compared,
// and the scan ends at the first hit or once every entry below the limit
// (limit = partition_count clipped to MAX_PARTS) has missed. tready is high
// only in the idle state, which the sequencer enters once the output register
// has taken the result. Input is taken only between items; a finished result
// waits in the output register so the next item can be taken. While that
// register still holds an unread result, the next result waits in the
// sequencer and input stays blocked.
// Depends on ffpa_pkg, ffpa_table and ffpa_seq.
`default_nettype none

module first_fit_partition_allocator #(
  parameter int MAX_PARTS  = ffpa_pkg::DEF_MAX_PARTS,
  parameter int SIZE_BITS  = ffpa_pkg::DEF_SIZE_BITS,
  parameter int OWNER_BITS = ffpa_pkg::DEF_OWNER_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] entry_index, [19:4] amount, [35:20] owner_id, [39:36] zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] found_index, [23:4] start_address
  output logic      [23:0] m_axis_tdata,
  // [0] status
  output logic      [0:0]  m_axis_tuser,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [ffpa_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ffpa_pkg::*;

  localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTS + 1);

  logic [CNT_CFG_W-1:0]  count_q;
  logic                  cfg_wr;

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  m_valid_q;
  res_t                  m_res_q;

  tbl_cmd_t              tbl_cmd;
  logic [IDX_W-1:0]      tbl_wr_idx;
  logic [SIZE_BITS-1:0]  tbl_wr_size;
  logic [ADDR_W-1:0]     tbl_wr_start;
  logic [OWNER_BITS-1:0] tbl_wr_owner;
  logic                  tbl_rd_en;
  logic [IDX_W-1:0]      tbl_rd_idx;
  logic [SIZE_BITS-1:0]  tbl_rd_size;
  logic [ADDR_W-1:0]     tbl_rd_start;
  logic [OWNER_BITS-1:0] tbl_rd_owner;
  logic                  tbl_rd_used;

  // APB register: partition_count
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PART_COUNT);
  assign prdata = (paddr[2] == REG_PART_COUNT) ? 32'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
    end else if (cfg_wr) begin
      count_q <= pwdata[CNT_CFG_W-1:0];
    end
  end

  // Output register decouples result delivery from the sequencer
  assign res_ready     = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.start, m_res_q.index};
  assign m_axis_tuser  = m_res_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  ffpa_seq #(
    .MAX_PARTS  (MAX_PARTS),
    .SIZE_BITS  (SIZE_BITS),
    .OWNER_BITS (OWNER_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (op_e'(s_axis_tuser)),
    .in_index_i     (s_axis_tdata[3:0]),
    .in_amount_i    (s_axis_tdata[19:4]),
    .in_owner_i     (s_axis_tdata[35:20]),
    .part_count_i   (count_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .tbl_cmd_o      (tbl_cmd),
    .tbl_wr_idx_o   (tbl_wr_idx),
    .tbl_wr_size_o  (tbl_wr_size),
    .tbl_wr_start_o (tbl_wr_start),
    .tbl_wr_owner_o (tbl_wr_owner),
    .tbl_rd_en_o    (tbl_rd_en),
    .tbl_rd_idx_o   (tbl_rd_idx),
    .tbl_rd_size_i  (tbl_rd_size),
    .tbl_rd_start_i (tbl_rd_start),
    .tbl_rd_owner_i (tbl_rd_owner),
    .tbl_rd_used_i  (tbl_rd_used)
  );

  ffpa_table #(
    .MAX_PARTS  (MAX_PARTS),
    .SIZE_BITS  (SIZE_BITS),
    .OWNER_BITS (OWNER_BITS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tbl_cmd),
    .wr_idx_i   (tbl_wr_idx),
    .wr_size_i  (tbl_wr_size),
    .wr_start_i (tbl_wr_start),
    .wr_owner_i (tbl_wr_owner),
    .rd_en_i    (tbl_rd_en),
    .rd_idx_i   (tbl_rd_idx),
    .rd_size_o  (tbl_rd_size),
    .rd_start_o (tbl_rd_start),
    .rd_owner_o (tbl_rd_owner),
    .rd_used_o  (tbl_rd_used)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for first_fit_partition_allocator: drives load, allocate and release items
// on the stream port and partition_count over APB, and checks each result against a
// table model kept here. Depends on ffpa_pkg and the allocator RTL.
module tb;
  import ffpa_pkg::*;

  localparam int NUM_PARTS    = DEF_MAX_PARTS;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 12;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam logic [PADDR_W-1:0] PART_COUNT_ADDR = {REG_PART_COUNT, 2'b00};

  // DUT ports
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata   = '0;   // [3:0] entry_index, [19:4] amount, [35:20] owner_id
  logic [1:0]  s_axis_tuser   = '0;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [23:0] m_axis_tdata;          // [3:0] found_index, [23:4] start_address
  logic [0:0]  m_axis_tuser;          // [0] status
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // Partition table as the block should hold it
  logic [AMT_W-1:0]     tbl_size  [NUM_PARTS];
  logic [ADDR_W-1:0]    tbl_start [NUM_PARTS];
  logic                 tbl_used  [NUM_PARTS] = '{default: 1'b0};
  logic [OWN_IN_W-1:0]  tbl_owner [NUM_PARTS];
  logic [ADDR_W-1:0]    next_start = '0;
  logic [CNT_CFG_W-1:0] part_count = CNT_RESET;

  res_t pending_results[$];
  res_t oldest_result;

  logic [OWN_IN_W-1:0] owner_pool [6] =
    '{16'h0000, 16'hFFFF, 16'h0001, 16'h1234, 16'hA5A5, 16'h5A5A};

  bit calm = 1'b0;            // no idling on either side while set
  int stall_reqs = 0;
  int sink_stalls_seen = 0;
  int sink_hold_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int alloc_hits = 0;
  int release_hits = 0;
  int settings_used = 0;
  int cycle_count = 0;

  first_fit_partition_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected result of one item; updates the table
  function automatic res_t predict_result(input logic [1:0] op, input logic [3:0] idx,
                                          input logic [AMT_W-1:0] amount,
                                          input logic [OWN_IN_W-1:0] owner);
    res_t r;
    int scan;
    bit hit;
    r.status = STATUS_FAIL;
    r.index  = '0;
    r.start  = '0;
    scan = (part_count > NUM_PARTS) ? NUM_PARTS : int'(part_count);
    hit = 1'b0;
    case (op)
      OP_LOAD: begin
        // index zero restarts the running sum
        if (idx == 4'd0) next_start = '0;
        tbl_size[idx]  = amount;
        tbl_start[idx] = next_start;
        tbl_used[idx]  = 1'b0;
        next_start     = next_start + {4'd0, amount};
        r.status = STATUS_OK;
        r.start  = tbl_start[idx];
      end
      OP_ALLOC: begin
        for (int i = 0; i < scan && !hit; i++) begin
          if (!tbl_used[i] && tbl_size[i] >= amount) begin
            tbl_used[i]  = 1'b1;
            tbl_owner[i] = owner;
            r.status = STATUS_OK;
            r.index  = i[3:0];
            r.start  = tbl_start[i];
            hit = 1'b1;
          end
        end
        if (hit) alloc_hits++;
      end
      OP_RELEASE: begin
        for (int i = 0; i < scan && !hit; i++) begin
          if (tbl_used[i] && tbl_owner[i] == owner) begin
            tbl_used[i] = 1'b0;
            r.status = STATUS_OK;
            r.index  = i[3:0];
            r.start  = tbl_start[i];
            hit = 1'b1;
          end
        end
        if (hit) release_hits++;
      end
      default: ;  // undefined operation: no change, failure
    endcase
    return r;
  endfunction

  // Send one item, with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                           input logic [AMT_W-1:0] amount, input logic [OWN_IN_W-1:0] owner);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, owner, amount, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_result(op, idx, amount, owner));
    items_sent++;
  endtask

  // Stop sending and let all results come back
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of partition_count, then read it back
  task automatic write_part_count(input logic [CNT_CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PART_COUNT_ADDR;
    pwdata  <= {{(32-CNT_CFG_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    part_count = value;
    settings_used++;
    // read-back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(32-CNT_CFG_W){1'b0}}, value}) begin
      $error("partition_count: expected %0d, got %0d", value, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [AMT_W-1:0] random_size();
    case ($urandom_range(7))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(8192));
    endcase
  endfunction

  function automatic logic [OWN_IN_W-1:0] random_owner();
    if ($urandom_range(9) < 8) return owner_pool[$urandom_range(5)];
    return 16'($urandom_range(65535));
  endfunction

  // Load all entries in index order
  task automatic reload_table();
    for (int i = 0; i < NUM_PARTS; i++)
      send_item(OP_LOAD, 4'(i), random_size(), 16'($urandom_range(65535)));
  endtask

  task automatic send_random_item();
    int pick;
    logic [AMT_W-1:0] req;
    pick = $urandom_range(99);
    if (pick < 4) begin
      reload_table();
    end else if (pick < 10) begin
      // single load, usually out of order
      send_item(OP_LOAD, 4'($urandom_range(15)), random_size(), 16'($urandom_range(65535)));
    end else if (pick < 14) begin
      send_item(OP_UNDEFINED, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)));
    end else if (pick < 57) begin
      case ($urandom_range(3))
        0, 1: req = 16'($urandom_range(4096));
        2: req = tbl_size[$urandom_range(NUM_PARTS - 1)];  // exact fit
        default: req = 16'($urandom_range(65535));
      endcase
      send_item(OP_ALLOC, 4'($urandom_range(15)), req, random_owner());
    end else begin
      send_item(OP_RELEASE, 4'($urandom_range(15)), 16'($urandom_range(65535)), random_owner());
    end
  endtask

  // Every entry loaded in order, size extremes included
  task automatic test_table_load();
    logic [AMT_W-1:0] sizes [NUM_PARTS] = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd4096,
      16'd32768, 16'd100, 16'd2000, 16'd50, 16'hFFFF, 16'd10, 16'd700, 16'd3, 16'd30000,
      16'd12345, 16'd8};
    for (int i = 0; i < NUM_PARTS; i++)
      send_item(OP_LOAD, 4'(i), sizes[i], 16'hFFFF);
  endtask

  // Allocate, release, miss and undefined operation
  task automatic test_alloc_release();
    send_item(OP_ALLOC, 4'd0, 16'd0, 16'h0000);       // zero-size entry fits zero
    send_item(OP_ALLOC, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(OP_ALLOC, 4'd0, 16'hFFFF, 16'h0001);
    send_item(OP_ALLOC, 4'd0, 16'hFFFF, 16'h0002);    // nothing left that big
    send_item(OP_RELEASE, 4'd0, 16'd0, 16'hFFFF);
    send_item(OP_RELEASE, 4'd15, 16'hFFFF, 16'h0002); // owner not found
    send_item(OP_UNDEFINED, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(OP_ALLOC, 4'd0, 16'd1, 16'h8000);
    send_item(OP_RELEASE, 4'd0, 16'd0, 16'h0000);
  endtask

  // Out-of-order loads carry the running sum past 2^20, then a clean reload
  task automatic test_address_wrap();
    for (int i = 0; i < 20; i++)
      send_item(OP_LOAD, 4'(1 + i % (NUM_PARTS - 1)), 16'hFFFF, 16'h0000);
    reload_table();
  endtask

  // Scan depth extremes: none, one, clipped to the table
  task automatic test_count_settings();
    logic [CNT_CFG_W-1:0] settings [5] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd16};
    foreach (settings[k]) begin
      wait_until_idle();
      write_part_count(settings[k]);
      send_item(OP_ALLOC, 4'd0, 16'd0, 16'h0042);
      send_item(OP_ALLOC, 4'd0, 16'hFFFF, 16'h0042);
      send_item(OP_RELEASE, 4'd0, 16'd0, 16'h0042);
      send_item(OP_RELEASE, 4'd0, 16'd0, 16'h0042);
    end
  endtask

  // Receiver holds off long enough for the input side to stall
  task automatic test_output_stall();
    stall_reqs++;
    for (int i = 0; i < 12; i++) send_random_item();
  endtask

  task automatic test_random_traffic();
    int phase_start;
    logic [CNT_CFG_W-1:0] setting;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: setting = 5'd16;
        1: setting = 5'd1;
        2: setting = 5'd0;
        3: setting = 5'd31;
        4: setting = 5'd17;
        default: setting = ($urandom_range(2) == 0) ? 5'd16 : 5'($urandom_range(1, 16));
      endcase
      wait_until_idle();
      write_part_count(setting);
      calm = (phase == 5);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_item();
    end
    calm = 1'b0;
  endtask

  // Result side ready, with random and requested hold-offs
  always @(posedge clk_i) begin
    if (sink_stalls_seen != stall_reqs) begin
      sink_stalls_seen = stall_reqs;
      sink_hold_left = HOLD_CYCLES;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with none expected");
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (m_axis_tuser[0] !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tdata[3:0] !== oldest_result.index) begin
          $error("found_index: expected %0d, got %0d", oldest_result.index,
                 m_axis_tdata[3:0]);
          error_count++;
        end
        if (m_axis_tdata[23:4] !== oldest_result.start) begin
          $error("start_address: expected 'h%0h, got 'h%0h", oldest_result.start,
                 m_axis_tdata[23:4]);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("first_fit_partition_allocator test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_alloc_release();
    test_address_wrap();
    test_count_settings();
    test_output_stall();
    test_random_traffic();
    wait_until_idle();
    $display("Sent %0d items, checked %0d results over %0d partition_count writes;",
             items_sent, results_checked, settings_used);
    $display("%0d allocations and %0d releases succeeded, %0d mismatches.",
             alloc_hits, release_hits, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("first_fit_partition_allocator test passed");
    end else begin
      $display("first_fit_partition_allocator test failed");
    end
    $finish;
  end

endmodule
